// ===== rtl/crsf_rx_pkg.sv =====
// Shared types, constants and the CRC-8 step function of the frame receiver.
package crsf_rx_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ADDR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TMO   = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_SYNC_ADDR = 8'd200;
  localparam logic [7:0]  RST_TX_ADDR   = 8'd234;
  localparam logic [7:0]  RST_RX_ADDR   = 8'd236;
  localparam logic [5:0]  RST_MAX_LEN   = 6'd62;
  localparam logic [7:0]  RST_CRC_POLY  = 8'd213;
  localparam logic [15:0] RST_GAP_TMO   = 16'd100;

  // Frame layout and length limits.
  localparam int MIN_LENGTH = 2;
  localparam int LEN_CAP    = 62;
  localparam int ADDR_SLOT  = 0;
  localparam int LEN_SLOT   = 1;
  localparam int BODY_SLOT  = 2;

  // Controller to datapath commands.
  typedef struct packed {
    logic note_time;    // store arrival time of the accepted item
    logic take_addr;    // start byte: open a frame
    logic take_len;     // length byte
    logic take_body;    // body byte: store, count, fold into CRC
    logic load_single;  // capture a one-item result
    logic acc;          // accepted flag for that result
    logic burst_start;  // read the first stored byte
    logic burst_next;   // read the following stored byte
    logic burst_mode;   // output shows stored frame bytes
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic gap_over;
    logic is_addr;
    logic len_ok;
    logic body_done;
    logic crc_match;
    logic burst_end;
  } stat_t;

  // One byte of a CRC-8, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crsf_frame_receiver_core.sv =====
// Top level of the frame receiver: ports, controller and datapath.
//
//  Channel  Direction  Payload (lowest bit first)           Handshake
//  s_*      in         tdata: rx_byte[7:0], arrival_ms[39:8]  tvalid/tready
//  m_*      out        tdata: frame_byte; tuser: accepted,   tvalid/tready
//                      byte_valid; tlast: last
//  cfg_*    in         cfg_index, cfg_data                    cfg_we
//
// Each input item yields one result item in the cycle after it is accepted, or,
// when it closes a frame with a good CRC, length+2 result items streamed from
// the frame store at one per cycle while m_tready is high; the store's single
// read port sets that pace. The next input item is taken once the last result
// of the current one has been delivered. Reset is synchronous and puts the
// parser in idle with the configuration at its defaults; the frame store needs
// no clearing. A low m_tready simply holds the current result item.
module crsf_frame_receiver_core import crsf_rx_pkg::*; #(
  parameter int MAX_FRAME = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input item stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // rx_byte[7:0], arrival_ms[39:8]
  // Result item stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // frame_byte[7:0]
  output logic [1:0]            m_tuser,   // accepted[0], byte_valid[1]
  output logic                  m_tlast,   // last result of this input item
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // The controller owns the parse phase and the output sequencing; all data
  // handling, including the frame store and the running CRC, is in the datapath.
  crsf_rx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  crsf_rx_dp #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata[7:0]),
    .arrival_ms(s_tdata[39:8]),
    .cmd       (cmd),
    .st        (st),
    .accepted  (m_tuser[0]),
    .byte_valid(m_tuser[1]),
    .frame_byte(m_tdata),
    .last      (m_tlast)
  );

endmodule

// ===== rtl/crsf_rx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crsf_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/crsf_rx_dp.sv =====
// Datapath of the frame receiver: configuration, timing, CRC, frame store and result.
module crsf_rx_dp import crsf_rx_pkg::*; #(
  parameter int MAX_FRAME = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           arrival_ms,
  input  cmd_t                  cmd,
  output stat_t                 st,
  output logic                  accepted,
  output logic                  byte_valid,
  output logic [7:0]            frame_byte,
  output logic                  last
);

  localparam int AW  = $clog2(MAX_FRAME);
  localparam int IW  = AW + 7;
  localparam int LIM = (MAX_FRAME - 2 < LEN_CAP) ? MAX_FRAME - 2 : LEN_CAP;
  localparam logic [5:0] LIM6 = 6'(LIM);

  logic [7:0]  sync_address;
  logic [7:0]  transmitter_address;
  logic [7:0]  receiver_address;
  logic [5:0]  max_length;
  logic [7:0]  crc_polynomial;
  logic [15:0] gap_timeout_ms;

  logic [31:0] last_arrival;
  logic [5:0]  body_count;
  logic [5:0]  length;
  logic [7:0]  crc;
  logic [AW-1:0] rd_idx;
  logic        acc;

  logic [31:0]   gap;
  logic [5:0]    eff_max;
  logic [IW-1:0] body_sum;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address        <= RST_SYNC_ADDR;
      transmitter_address <= RST_TX_ADDR;
      receiver_address    <= RST_RX_ADDR;
      max_length          <= RST_MAX_LEN;
      crc_polynomial      <= RST_CRC_POLY;
      gap_timeout_ms      <= RST_GAP_TMO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_ADDR: sync_address        <= cfg_data[7:0];
        REG_TX_ADDR:   transmitter_address <= cfg_data[7:0];
        REG_RX_ADDR:   receiver_address    <= cfg_data[7:0];
        REG_MAX_LEN:   max_length          <= cfg_data[5:0];
        REG_CRC_POLY:  crc_polynomial      <= cfg_data[7:0];
        REG_GAP_TMO:   gap_timeout_ms      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_arrival <= '0;
      body_count   <= '0;
    end else begin
      if (cmd.note_time) begin
        last_arrival <= arrival_ms;
      end
      if (cmd.take_addr) begin
        body_count <= '0;
      end else if (cmd.take_body) begin
        body_count <= body_count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_addr) begin
      crc <= '0;
    end else if (cmd.take_body) begin
      crc <= crc8_step(crc, rx_byte, crc_polynomial);
    end
    if (cmd.take_len) begin
      length <= rx_byte[5:0];
    end
    if (cmd.burst_start) begin
      rd_idx <= '0;
    end else if (cmd.burst_next) begin
      rd_idx <= rd_idx + AW'(1);
    end
    if (cmd.load_single) begin
      acc <= cmd.acc;
    end
  end

  assign gap     = arrival_ms - last_arrival;
  assign eff_max = (max_length > LIM6) ? LIM6 : max_length;

  assign st.gap_over  = gap > {16'd0, gap_timeout_ms};
  assign st.is_addr   = (rx_byte == sync_address) || (rx_byte == transmitter_address) ||
                        (rx_byte == receiver_address);
  assign st.len_ok    = (rx_byte >= 8'(MIN_LENGTH)) && (rx_byte <= {2'b00, eff_max});
  assign st.body_done = (body_count + 6'd1) == length;
  assign st.crc_match = rx_byte == crc;
  assign st.burst_end = IW'(rd_idx) == (IW'(length) + IW'(1));

  // Frame store: address, length, then body bytes.
  assign body_sum  = IW'(body_count) + IW'(BODY_SLOT);
  assign ram_we    = cmd.take_addr || cmd.take_len || cmd.take_body;
  assign ram_waddr = cmd.take_addr ? AW'(ADDR_SLOT) :
                     cmd.take_len  ? AW'(LEN_SLOT)  : body_sum[AW-1:0];
  assign ram_re    = cmd.burst_start || cmd.burst_next;
  assign ram_raddr = cmd.burst_start ? AW'(ADDR_SLOT) : rd_idx + AW'(1);

  crsf_rx_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign accepted   = cmd.burst_mode ? 1'b1 : acc;
  assign byte_valid = cmd.burst_mode;
  assign frame_byte = cmd.burst_mode ? ram_rdata : 8'd0;
  assign last       = cmd.burst_mode ? st.burst_end : 1'b1;

endmodule

// ===== rtl/crsf_rx_ctrl.sv =====
// Controller of the frame receiver: parse phase and output sequencing.
module crsf_rx_ctrl import crsf_rx_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] OS_IN    = 2'd0;
  localparam logic [1:0] OS_ONE   = 2'd1;
  localparam logic [1:0] OS_BURST = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] ostate, ostate_next;
  logic [1:0] eff_phase;
  logic       in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      ostate <= OS_IN;
    end else begin
      phase  <= phase_next;
      ostate <= ostate_next;
    end
  end

  assign in_ready  = ostate == OS_IN;
  assign out_valid = ostate != OS_IN;
  assign in_fire   = in_valid && in_ready;
  // A long gap inside a frame drops the parser back to idle before the item is looked at.
  assign eff_phase = (phase != PH_IDLE && st.gap_over) ? PH_IDLE : phase;

  always_comb begin
    cmd             = '0;
    cmd.burst_mode  = ostate == OS_BURST;
    phase_next      = phase;
    ostate_next     = ostate;
    case (ostate)
      OS_IN: begin
        if (in_fire) begin
          cmd.note_time   = 1'b1;
          cmd.load_single = 1'b1;
          ostate_next     = OS_ONE;
          case (eff_phase)
            PH_LEN: begin
              if (st.len_ok) begin
                cmd.take_len = 1'b1;
                cmd.acc      = 1'b1;
                phase_next   = PH_BODY;
              end else begin
                phase_next = PH_IDLE;
              end
            end
            PH_BODY: begin
              cmd.take_body = 1'b1;
              if (st.body_done) begin
                phase_next = PH_IDLE;
                if (st.crc_match) begin
                  cmd.burst_start = 1'b1;
                  ostate_next     = OS_BURST;
                end
              end else begin
                cmd.acc = 1'b1;
              end
            end
            default: begin
              phase_next = PH_IDLE;
              if (st.is_addr) begin
                cmd.take_addr = 1'b1;
                cmd.acc       = 1'b1;
                phase_next    = PH_LEN;
              end
            end
          endcase
        end
      end
      OS_ONE: begin
        if (out_ready) begin
          ostate_next = OS_IN;
        end
      end
      OS_BURST: begin
        if (out_ready) begin
          if (st.burst_end) begin
            ostate_next = OS_IN;
          end else begin
            cmd.burst_next = 1'b1;
          end
        end
      end
      default: ostate_next = OS_IN;
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  a_burst_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.burst_start |=> (ostate == OS_BURST))
    else $error("frame burst did not start");

  a_no_read_past_end: assert property (@(posedge clk) disable iff (rst)
    cmd.burst_next |-> !st.burst_end)
    else $error("store read past the end of the frame");

endmodule

// ===== verif/crsf_frame_checker.sv =====
// Checker for the frame receiver: models the parser and compares every result item.
`timescale 1ns / 100ps

module crsf_frame_checker import crsf_rx_pkg::*; #(
  parameter int MAX_FRAME = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [39:0]           s_tdata,   // rx_byte[7:0], arrival_ms[39:8]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,   // frame_byte[7:0]
  input  logic [1:0]            m_tuser,   // accepted[0], byte_valid[1]
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    awaited,
  output int                    results_seen,
  output int                    frames_passed
);

  typedef enum logic [1:0] {P_IDLE, P_LENGTH, P_BODY} parse_phase_t;

  typedef struct packed {
    logic       accepted;
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic       last;
  } reply_t;

  // Register copies.
  logic [7:0]  sync_addr, tx_addr, rx_addr, crc_poly;
  logic [5:0]  len_limit;
  logic [15:0] gap_tmo;

  // Parser copy.
  parse_phase_t phase;
  logic [5:0]   body_cnt;
  logic [7:0]   frame_buf [MAX_FRAME];
  logic [31:0]  last_ms;

  reply_t replies_due [$];
  int     errs = 0;
  int     seen = 0;
  int     good = 0;
  int     shown = 0;

  function automatic int length_ceiling();
    int m;
    m = len_limit;
    if (m > LEN_CAP) m = LEN_CAP;
    if (m > MAX_FRAME - 2) m = MAX_FRAME - 2;
    return m;
  endfunction

  // CRC-8 over the first n body bytes held in the frame buffer.
  function automatic logic [7:0] body_crc(input int n);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < n; i++) begin
      c = c ^ frame_buf[BODY_SLOT + i];
      for (int k = 0; k < 8; k++) begin
        if (c[7]) c = {c[6:0], 1'b0} ^ crc_poly;
        else      c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void queue_reply(input logic acc, input logic vld,
                                      input logic [7:0] b, input logic lst);
    reply_t r;
    r.accepted   = acc;
    r.byte_valid = vld;
    r.frame_byte = b;
    r.last       = lst;
    replies_due.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] rx, input logic [31:0] now);
    logic [31:0] gap;
    int          total;
    gap = now - last_ms;
    if (phase != P_IDLE && gap > {16'h0000, gap_tmo}) begin
      phase    = P_IDLE;
      body_cnt = '0;
    end
    last_ms = now;
    case (phase)
      P_LENGTH: begin
        if (rx < MIN_LENGTH || rx > length_ceiling()) begin
          phase = P_IDLE;
          queue_reply(1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
          phase               = P_BODY;
          frame_buf[LEN_SLOT] = rx;
          queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
        end
      end
      P_BODY: begin
        frame_buf[BODY_SLOT + body_cnt] = rx;
        body_cnt = body_cnt + 6'd1;
        if (frame_buf[LEN_SLOT] == {2'b00, body_cnt}) begin
          phase = P_IDLE;
          if (rx == body_crc(int'(body_cnt) - 1)) begin
            total = int'(frame_buf[LEN_SLOT]) + 2;
            for (int i = 0; i < total; i++)
              queue_reply(1'b1, 1'b1, frame_buf[i], i == total - 1);
            good++;
          end else begin
            queue_reply(1'b0, 1'b0, 8'h00, 1'b1);
          end
        end else begin
          queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
        end
      end
      default: begin
        phase = P_IDLE;
        if (rx == sync_addr || rx == tx_addr || rx == rx_addr) begin
          body_cnt             = '0;
          phase                = P_LENGTH;
          frame_buf[ADDR_SLOT] = rx;
          queue_reply(1'b1, 1'b0, 8'h00, 1'b1);
        end else begin
          queue_reply(1'b0, 1'b0, 8'h00, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : track
    reply_t got, want;
    if (rst) begin
      sync_addr = RST_SYNC_ADDR;
      tx_addr   = RST_TX_ADDR;
      rx_addr   = RST_RX_ADDR;
      len_limit = RST_MAX_LEN;
      crc_poly  = RST_CRC_POLY;
      gap_tmo   = RST_GAP_TMO;
      phase     = P_IDLE;
      body_cnt  = '0;
      last_ms   = '0;
      replies_due.delete();
    end else begin
      // Results are taken before new inputs so that a result appearing in the
      // same cycle as its own input is caught as unexpected.
      if (m_tvalid && m_tready) begin
        got.accepted   = m_tuser[0];
        got.byte_valid = m_tuser[1];
        got.frame_byte = m_tdata;
        got.last       = m_tlast;
        seen++;
        if (replies_due.size() == 0) begin
          errs++;
          if (shown < 25)
            $display("%0t: unexpected result: expected none, %s acc=%0b vld=%0b byte=%02h last=%0b",
                     $time, "got", got.accepted, got.byte_valid, got.frame_byte, got.last);
          shown++;
        end else begin
          want = replies_due.pop_front();
          if (got.accepted !== want.accepted || got.byte_valid !== want.byte_valid ||
              got.frame_byte !== want.frame_byte || got.last !== want.last) begin
            errs++;
            if (shown < 25)
              $display("%0t: result %0d: expected acc=%0b vld=%0b byte=%02h last=%0b, %s%0b%s",
                       $time, seen, want.accepted, want.byte_valid, want.frame_byte,
                       want.last, "got acc=", got.accepted,
                       $sformatf(" vld=%0b byte=%02h last=%0b",
                                 got.byte_valid, got.frame_byte, got.last));
            shown++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_ADDR: sync_addr = cfg_data[7:0];
          REG_TX_ADDR:   tx_addr   = cfg_data[7:0];
          REG_RX_ADDR:   rx_addr   = cfg_data[7:0];
          REG_MAX_LEN:   len_limit = cfg_data[5:0];
          REG_CRC_POLY:  crc_poly  = cfg_data[7:0];
          REG_GAP_TMO:   gap_tmo   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        parse_byte(s_tdata[7:0], s_tdata[39:8]);
    end
    mismatches    <= errs;
    awaited       <= replies_due.size();
    results_seen  <= seen;
    frames_passed <= good;
  end

endmodule

// ===== verif/tb_crsf_frame_receiver_core.sv =====
// Testbench top for the frame receiver: stimulus, register settings and verdict.
`timescale 1ns / 100ps

module tb_crsf_frame_receiver_core;
  import crsf_rx_pkg::*;

  localparam int MAX_FRAME   = 64;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE      = 8;
  // Roughly 320 items, each at worst the longest input wait plus 64 results that
  // each wait out the longest stall, taken about four times over.
  localparam int CYCLE_LIMIT = 1_500_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [39:0]           s_tdata = '0;   // rx_byte[7:0], arrival_ms[39:8]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // frame_byte[7:0]
  logic [1:0]            m_tuser;        // accepted[0], byte_valid[1]
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SYNC_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches, awaited, results_seen, frames_passed;

  // The stimulus keeps its own copy of the registers so that it can aim at
  // the start addresses, stay within the length limit and build trailers.
  logic [7:0]  addr_tab [3] = '{RST_SYNC_ADDR, RST_TX_ADDR, RST_RX_ADDR};
  logic [5:0]  len_max  = RST_MAX_LEN;
  logic [7:0]  poly     = RST_CRC_POLY;
  logic [15:0] tmo      = RST_GAP_TMO;
  logic [31:0] clock_ms = '0;
  bit          quiet    = 1'b0;
  int          sent     = 0;
  int          cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crsf_frame_receiver_core #(.MAX_FRAME(MAX_FRAME)) DUT (.*);

  crsf_frame_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (.*);

  // Wait drawn before each item on either side. In a quiet stretch both
  // sides run flat out; otherwise about a quarter of the draws are zero.
  function automatic int draw_wait();
    if (quiet) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // One byte of the trailer, MSB first, with the polynomial now in force.
  function automatic logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    return v;
  endfunction

  // Offers one item and holds it until the block takes it. A zero gap keeps
  // tvalid high straight into the next item, so it is only ever assigned once
  // per clock edge.
  task automatic send_item(input logic [7:0] b, input logic [31:0] t);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, b};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic put(input logic [7:0] b, input int unsigned dt);
    clock_ms = clock_ms + dt;
    send_item(b, clock_ms);
  endtask

  // Advances the millisecond clock and sends. A long gap overruns the timeout
  // and should throw away a frame in progress; otherwise the gap sometimes
  // lands exactly on the timeout, which must not abort.
  task automatic feed(input logic [7:0] b, input bit long_gap);
    int unsigned step;
    if (long_gap)                       step = tmo + 1 + $urandom_range(0, 300);
    else if ($urandom_range(0, 7) == 0) step = tmo;
    else                                step = $urandom_range(0, tmo);
    put(b, step);
  endtask

  // One frame attempt. With a forced length it is always a clean frame;
  // otherwise it may carry a bad length, a bad trailer or a timeout part way.
  task automatic send_frame(input int forced_len);
    int         lim, len, kind, cut;
    logic [7:0] crc, b;
    lim  = (len_max > LEN_CAP) ? LEN_CAP : len_max;
    kind = (forced_len > 0) ? 99 : $urandom_range(0, 99);
    cut  = (kind >= 25 && kind < 35) ? $urandom_range(0, 8) : -1;
    feed(addr_tab[$urandom_range(0, 2)], 1'b0);
    if (forced_len == 0 && (kind < 10 || lim < MIN_LENGTH)) begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(lim + 1, 255));
      feed(b, 1'b0);
    end else begin
      if (forced_len > 0)                len = forced_len;
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(MIN_LENGTH, lim);
      else                               len = $urandom_range(MIN_LENGTH, (lim < 8) ? lim : 8);
      feed(8'(len), cut == 0);
      crc = 8'h00;
      for (int i = 1; i < len; i++) begin
        b   = 8'($urandom);
        crc = crc_next(crc, b);
        feed(b, cut == i);
      end
      if (kind < 25) crc = crc ^ 8'($urandom_range(1, 255));
      feed(crc, cut == len);
    end
  endtask

  // Stray bytes, sometimes after a large jump of the millisecond clock.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) clock_ms = clock_ms + $urandom();
      feed(8'($urandom), 1'b0);
    end
  endtask

  task automatic run_random(input int target);
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else                           send_frame(0);
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
    end
    quiet = 1'b0;
  endtask

  // Lowers tvalid and waits until every expected result has been delivered,
  // then waits out the SETTLE period so that the block comes to rest.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Writes all six registers back to back; the write enable drops only after
  // the last one.
  task automatic apply_setup(input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
                             input logic [5:0] ml, input logic [7:0] pl, input logic [15:0] gt);
    write_reg(REG_SYNC_ADDR, {8'h00, a0});
    write_reg(REG_TX_ADDR,   {8'h00, a1});
    write_reg(REG_RX_ADDR,   {8'h00, a2});
    write_reg(REG_MAX_LEN,   {10'h000, ml});
    write_reg(REG_CRC_POLY,  {8'h00, pl});
    write_reg(REG_GAP_TMO,   gt);
    cfg_we   <= 1'b0;
    addr_tab  = '{a0, a1, a2};
    len_max   = ml;
    poly      = pl;
    tmo       = gt;
    clock_ms  = $urandom();
  endtask

  // The result side draws its own stall before every result item.
  initial begin : sink_side
    int hold;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the registers at their reset values so that
    // those are checked too. Stray bytes at the extremes of both fields.
    send_item(8'h00, 32'h0000_0000);
    send_item(8'hFF, 32'hFFFF_FFFF);
    // A shortest good frame whose bytes straddle the wrap of the clock.
    clock_ms = 32'hFFFF_FFF0;
    put(RST_SYNC_ADDR, 0);
    put(8'd2, 10);
    put(8'hA5, 22);
    put(crc_next(8'h00, 8'hA5), 16);
    // Lengths below the minimum (one and zero) and just above the maximum.
    put(RST_TX_ADDR, 5);
    put(8'd1, 5);
    put(RST_RX_ADDR, 5);
    put(8'd0, 5);
    put(RST_SYNC_ADDR, 5);
    put(8'd63, 5);
    // A frame with a wrong trailer.
    put(RST_RX_ADDR, 5);
    put(8'd3, 5);
    put(8'h11, 5);
    put(8'h22, 5);
    put(crc_next(crc_next(8'h00, 8'h11), 8'h22) ^ 8'h01, 5);
    // One millisecond beyond the timeout drops the frame, and the length
    // byte is then seen in idle.
    put(RST_SYNC_ADDR, 5);
    put(8'd4, 101);
    // Gaps of exactly the timeout keep the frame alive.
    put(RST_TX_ADDR, 5);
    put(8'd2, 100);
    put(8'h7E, 100);
    put(crc_next(8'h00, 8'h7E), 100);

    // Random part under the reset setting, opened by a frame of the largest
    // length, which streams 64 result items.
    send_frame(LEN_CAP);
    run_random(110);
    settle_block();

    // Extreme addresses, the smallest length limit that still admits a frame, an all-ones
    // polynomial and a zero timeout, so that any gap at all aborts a frame.
    apply_setup(8'h00, 8'hFF, 8'h80, 6'd2, 8'hFF, 16'h0000);
    run_random(170);
    settle_block();

    // A limit register above the cap, a zero polynomial, the longest timeout.
    apply_setup(8'($urandom), 8'($urandom), 8'($urandom), 6'd63, 8'h00, 16'hFFFF);
    send_frame(LEN_CAP);
    run_random(230);
    settle_block();

    // A limit below the minimum length turns every length away.
    apply_setup(8'($urandom), 8'($urandom), 8'($urandom), 6'd0, 8'($urandom),
                16'($urandom_range(0, 400)));
    run_random(245);
    settle_block();

    // Everything drawn at random within the legal ranges.
    apply_setup(8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom_range(2, 62)),
                8'($urandom), 16'($urandom));
    run_random(315);
    settle_block();
    repeat (4 * SETTLE) @(posedge clk);

    $display("Sent %0d input items under five register settings, directed cases first.", sent);
    $display("Checked %0d result items, %0d of them within %0d good frames.",
             results_seen, results_seen - (sent - frames_passed), frames_passed);
    if (mismatches == 0 && awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still awaited.", cycles, awaited);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/crsf_rx_pkg.sv
rtl/crsf_rx_ram.sv
rtl/crsf_rx_dp.sv
rtl/crsf_rx_ctrl.sv
rtl/crsf_frame_receiver_core.sv
verif/crsf_frame_checker.sv
verif/tb_crsf_frame_receiver_core.sv
